/* hw/rtl/fcv_pkg.sv */
// Package for the FIR convolver: default sizes, fixed field widths and item codes.
// No dependencies; imported by fir_convolver.

package fcv_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_MAX_TAPS    = 1024;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_COEF_BITS   = 16;

    // Fixed widths of the coefficient index and the tap count register
    localparam int COEF_IDX_W = 10;
    localparam int TAP_CNT_W  = 11;

    localparam logic [TAP_CNT_W-1:0] TAP_CNT_RST = TAP_CNT_W'(1024);

    // Item kinds carried on tuser
    localparam logic FUNC_COEF   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

endpackage : fcv_pkg

/* hw/rtl/fir_convolver.sv */
// Direct-form FIR convolver with a loadable impulse response.
// Depends on fcv_pkg for default sizes, field widths and item codes.

// After reset the block clears every entry of its delay line and
// coefficient memories (tready stays low; tap count writes are still taken).
// A coefficient transaction (tuser = 0) is absorbed and gives no output. For
// a sample transaction (tuser = 1) a single shared multiply-accumulate reads
// one tap per cycle from the two single-port-read memories; then the
// pipeline drains and the sum is rounded and saturated. The result is the
// filter output for the samples stored before this one, so the input shows
// up one sample later. A new transaction is accepted while a previous result
// is still waiting in the output register. The tap count may only be changed
// while the block is idle; zero acts as one and values above MAX_TAPS act as
// MAX_TAPS.

module fir_convolver
    import fcv_pkg::*;
#(
    parameter int MAX_TAPS    = DEF_MAX_TAPS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = DEF_COEF_BITS,
    localparam int IN_W       = ((COEF_IDX_W + COEF_BITS + SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Tap count register
    input  logic                 i_cfg_we,
    input  logic [TAP_CNT_W-1:0] i_cfg_wdata,
    // Input stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata, lowest bit up: coef_index, coef_value, sample_in, zero padding
    input  logic [IN_W-1:0]      i_s_axis_tdata,
    // tuser: func
    input  logic                 i_s_axis_tuser,
    // Output stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata, lowest bit up: out_sample, zero padding
    output logic [OUT_W-1:0]     o_m_axis_tdata
);

    localparam int AW       = $clog2(MAX_TAPS);
    localparam int CW       = ((TAP_CNT_W > AW) ? TAP_CNT_W : AW) + 1;
    localparam int XW       = ((COEF_IDX_W > AW) ? COEF_IDX_W : AW) + 1;
    localparam int PW       = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_FULL = PW + AW + 1;
    localparam int ACC_W    = (ACC_FULL > 64) ? 64 : ACC_FULL;
    localparam int RW       = ACC_W - COEF_BITS + 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [AW-1:0]    LAST_ADDR = AW'(MAX_TAPS - 1);
    localparam logic [ACC_W-1:0] RND_HALF  = ACC_W'(1) << (COEF_BITS - 2);
    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Memories
    logic [SAMPLE_BITS-1:0] r_dl_mem [MAX_TAPS];
    logic [COEF_BITS-1:0]   r_cf_mem [MAX_TAPS];

    logic [2:0]                    r_state;
    logic [AW-1:0]                 r_clr_addr;
    logic [TAP_CNT_W-1:0]          r_tap_count;
    logic [AW-1:0]                 r_wp;
    logic [AW-1:0]                 r_base;
    logic [AW-1:0]                 r_last;
    logic [AW-1:0]                 r_ptr;
    logic [AW-1:0]                 r_j;
    logic [SAMPLE_BITS-1:0]        r_sample;
    logic                          r_rd_vld;
    logic                          r_prod_vld;
    logic signed [SAMPLE_BITS-1:0] r_dl_rd;
    logic signed [COEF_BITS-1:0]   r_cf_rd;
    logic signed [PW-1:0]          r_prod;
    logic [ACC_W-1:0]              r_acc;
    logic [SAMPLE_BITS-1:0]        r_out;
    logic                          r_out_vld;

    logic                   s_accept;
    logic                   out_free;
    logic [COEF_IDX_W-1:0]  in_idx;
    logic [COEF_BITS-1:0]   in_coef;
    logic [SAMPLE_BITS-1:0] in_sample;
    logic [XW-1:0]          idx_x;
    logic                   idx_ok;
    logic [CW-1:0]          tc_x;
    logic [CW-1:0]          tc_m1;
    logic [AW-1:0]          last_eff;
    logic [AW-1:0]          wp0;
    logic [AW-1:0]          wp_next;
    logic                   rd_issue;
    logic                   dl_we;
    logic [AW-1:0]          dl_waddr;
    logic [SAMPLE_BITS-1:0] dl_wdata;
    logic                   cf_we;
    logic [AW-1:0]          cf_waddr;
    logic [COEF_BITS-1:0]   cf_wdata;
    logic [ACC_W-1:0]       rnd_sum;
    logic [RW-1:0]          rnd_val;
    logic [RW-SAMPLE_BITS:0] rnd_top;
    logic [SAMPLE_BITS-1:0] sat_val;

    assign in_idx    = i_s_axis_tdata[COEF_IDX_W-1:0];
    assign in_coef   = i_s_axis_tdata[COEF_IDX_W +: COEF_BITS];
    assign in_sample = i_s_axis_tdata[COEF_IDX_W + COEF_BITS +: SAMPLE_BITS];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_W'(r_out);

    assign idx_x  = XW'(in_idx);
    assign idx_ok = idx_x < XW'(MAX_TAPS);

    // Last tap index in use: a count of zero acts as one, larger counts clamp.
    assign tc_x  = CW'(r_tap_count);
    assign tc_m1 = tc_x - CW'(1);
    always_comb begin
        priority if (tc_x == '0) begin
            last_eff = '0;
        end else if (tc_x > CW'(MAX_TAPS)) begin
            last_eff = LAST_ADDR;
        end else begin
            last_eff = tc_m1[AW-1:0];
        end
    end

    assign wp0     = (r_wp > last_eff) ? '0 : r_wp;
    assign wp_next = (r_base == r_last) ? '0 : r_base + AW'(1);

    assign rd_issue = (r_state == ST_READ);

    // Memory write ports
    always_comb begin
        dl_we    = (r_state == ST_CLEAR) || (r_state == ST_DRAIN);
        dl_waddr = (r_state == ST_CLEAR) ? r_clr_addr : wp_next;
        dl_wdata = (r_state == ST_CLEAR) ? '0 : r_sample;
        cf_we    = (r_state == ST_CLEAR)
                   || (s_accept && (i_s_axis_tuser == FUNC_COEF) && idx_ok);
        cf_waddr = (r_state == ST_CLEAR) ? r_clr_addr : idx_x[AW-1:0];
        cf_wdata = (r_state == ST_CLEAR) ? '0 : in_coef;
    end

    always_ff @(posedge i_clk) begin
        if (dl_we) begin
            r_dl_mem[dl_waddr] <= dl_wdata;
        end
        if (rd_issue) begin
            r_dl_rd <= r_dl_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cf_we) begin
            r_cf_mem[cf_waddr] <= cf_wdata;
        end
        if (rd_issue) begin
            r_cf_rd <= r_cf_mem[r_j];
        end
    end

    // Round to nearest (ties upward), drop the fraction, then saturate.
    assign rnd_sum = r_acc + RND_HALF;
    assign rnd_val = rnd_sum[ACC_W-1:COEF_BITS-1];
    assign rnd_top = rnd_val[RW-1:SAMPLE_BITS-1];
    always_comb begin
        if ((&rnd_top) || !(|rnd_top)) begin
            sat_val = rnd_val[SAMPLE_BITS-1:0];
        end else if (rnd_val[RW-1]) begin
            sat_val = SAT_MIN;
        end else begin
            sat_val = SAT_MAX;
        end
    end

    // Multiply-accumulate datapath
    always_ff @(posedge i_clk) begin
        r_prod <= r_dl_rd * r_cf_rd;
        if (s_accept) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (s_accept) begin
            r_sample <= in_sample;
            r_base   <= wp0;
            r_ptr    <= wp0;
            r_last   <= last_eff;
            r_j      <= '0;
        end else if (rd_issue) begin
            r_ptr <= (r_ptr == '0) ? r_last : r_ptr - AW'(1);
            r_j   <= r_j + AW'(1);
        end
        if ((r_state == ST_FINISH) && out_free) begin
            r_out <= sat_val;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_tap_count <= TAP_CNT_RST;
            r_wp        <= '0;
            r_rd_vld    <= 1'b0;
            r_prod_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_wdata;
            end
            r_rd_vld   <= rd_issue;
            r_prod_vld <= r_rd_vld;

            if ((r_state == ST_FINISH) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept && (i_s_axis_tuser == FUNC_SAMPLE)) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (r_j == r_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // The new sample is stored here, after its slot was last read.
                    r_wp <= wp_next;
                    if (!r_rd_vld && !r_prod_vld) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule : fir_convolver

/* tb/fir_convolver_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fir_convolver: drives coefficient and sample transactions,
// predicts every filtered sample and compares it with the output stream.
// Depends on fcv_pkg and fir_convolver.

module fir_convolver_test;
    import fcv_pkg::*;

    localparam int TAPS   = DEF_MAX_TAPS;
    localparam int SMP_W  = DEF_SAMPLE_BITS;
    localparam int COEF_W = DEF_COEF_BITS;
    localparam int IN_W   = ((COEF_IDX_W + COEF_W + SMP_W + 7) / 8) * 8;
    localparam int OUT_W  = ((SMP_W + 7) / 8) * 8;

    localparam int HOLD_CYCLES  = 3000;
    localparam int SETTLE_DELAY = 32;
    localparam int NUM_PHASES   = 12;
    localparam int PHASE_TAPS [NUM_PHASES] = '{0, 2, 2047, 7, 64, 5, 1023, 16, 3, 1024, 33, 1};
    localparam int PHASE_LEN  [NUM_PHASES] = '{40, 50, 25, 60, 70, 50, 20, 70, 60, 15, 60, 40};

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} t_rx_mode;

    // Keeps its own copy of the filter state and the filtered samples still owed.
    class fir_scoreboard;
        logic signed [SMP_W-1:0]  delay_mem [TAPS];
        logic signed [COEF_W-1:0] coef_mem [TAPS];
        int                       wr_ptr;
        logic [TAP_CNT_W-1:0]     tap_reg;
        logic [SMP_W-1:0]         owed_samples [$];
        int                       mismatches;
        int                       results_seen;

        function new();
            for (int i = 0; i < TAPS; i++) begin
                delay_mem[i] = '0;
                coef_mem[i]  = '0;
            end
            wr_ptr       = 0;
            tap_reg      = TAP_CNT_RST;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_taps(logic [TAP_CNT_W-1:0] value);
            tap_reg = value;
        endfunction

        function int active_taps();
            if (tap_reg == 0)
                return 1;
            if (tap_reg > TAPS)
                return TAPS;
            return int'(tap_reg);
        endfunction

        function int pending();
            return owed_samples.size();
        endfunction

        function void note_input(logic func, logic [IN_W-1:0] data);
            logic [COEF_IDX_W-1:0]    idx;
            logic signed [SMP_W-1:0]  smp;
            logic signed [SMP_W-1:0]  y;
            longint                   acc;
            longint                   rounded;
            int                       n;
            int                       p;
            int                       j;
            idx = data[COEF_IDX_W-1:0];
            smp = data[COEF_IDX_W+COEF_W +: SMP_W];
            if (func == FUNC_COEF) begin
                coef_mem[idx] = data[COEF_IDX_W +: COEF_W];
                return;
            end
            n = active_taps();
            // A pointer left behind by a longer delay line restarts at the front.
            if (wr_ptr >= n)
                wr_ptr = 0;
            acc = 0;
            p = wr_ptr;
            for (j = 0; j < n; j++) begin
                acc += longint'(delay_mem[p]) * longint'(coef_mem[j]);
                p = (p == 0) ? n - 1 : p - 1;
            end
            rounded = (acc + (longint'(1) << (COEF_W - 2))) >>> (COEF_W - 1);
            if (rounded > longint'((1 << (SMP_W - 1)) - 1))
                y = {1'b0, {(SMP_W-1){1'b1}}};
            else if (rounded < -longint'(1 << (SMP_W - 1)))
                y = {1'b1, {(SMP_W-1){1'b0}}};
            else
                y = rounded[SMP_W-1:0];
            owed_samples.push_back(y);
            // The new sample is stored only after the sum, hence the one-sample delay.
            wr_ptr = (wr_ptr + 1 >= n) ? 0 : wr_ptr + 1;
            delay_mem[wr_ptr] = smp;
        endfunction

        function void check_result(logic [SMP_W-1:0] got);
            logic [SMP_W-1:0] want;
            results_seen++;
            if (owed_samples.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Output %0d: sample %h arrived with nothing outstanding",
                             results_seen, got);
                return;
            end
            want = owed_samples.pop_front();
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Output %0d: out_sample expected %h, got %h",
                             results_seen, want, got);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [TAP_CNT_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    int                   hold_requests = 0;
    int                   burst_left = 0;
    bit                   no_gaps = 1'b0;
    fir_scoreboard        board;

    fir_convolver uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #(2_000_000 * 8);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [IN_W-1:0] pack_item(logic [COEF_IDX_W-1:0] idx,
                                                  logic [COEF_W-1:0] coef,
                                                  logic [SMP_W-1:0] smp);
        logic [IN_W-1:0] data;
        data = '0;
        data[COEF_IDX_W-1:0]             = idx;
        data[COEF_IDX_W +: COEF_W]       = coef;
        data[COEF_IDX_W+COEF_W +: SMP_W] = smp;
        return data;
    endfunction

    // Extremes, near-zero values, small amplitudes and the full range, mixed.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 511) - 256);
            3:       return 16'($urandom_range(0, 2) - 1);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic push_item(input logic func, input logic [IN_W-1:0] data);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_input(func, data);
    endtask

    task automatic push_coef(input int idx, input int value);
        push_item(FUNC_COEF, pack_item(COEF_IDX_W'(idx), COEF_W'(value), 16'($urandom())));
    endtask

    task automatic push_sample(input int value);
        push_item(FUNC_SAMPLE, pack_item(COEF_IDX_W'($urandom()), 16'($urandom()),
                                         SMP_W'(value)));
    endtask

    // Once every result is in, let the block sit idle before the tap count is touched.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_DELAY) @(posedge clk);
    endtask

    task automatic set_tap_count(input int value);
        cfg_we    <= 1'b1;
        cfg_wdata <= TAP_CNT_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_taps(TAP_CNT_W'(value));
    endtask

    task automatic run_random_phase(input int taps, input int n_items, input bit hold_output);
        logic                  func;
        logic [COEF_IDX_W-1:0] idx;
        int                    span;
        int                    k;
        wait_drained();
        set_tap_count(taps);
        // The output side holds off for a long stretch while items keep coming.
        if (hold_output)
            hold_requests <= hold_requests + 1;
        span = board.active_taps();
        for (k = 0; k < n_items; k++) begin
            func = ($urandom_range(0, 99) < 30) ? FUNC_COEF : FUNC_SAMPLE;
            if ($urandom_range(0, 99) < 80)
                idx = COEF_IDX_W'($urandom_range(0, span - 1));
            else
                idx = COEF_IDX_W'($urandom());
            push_item(func, pack_item(idx, pick_value(), pick_value()));
        end
    endtask

    initial begin : receiver
        t_rx_mode mode;
        int       mode_left;
        int       hold_left;
        int       hold_served;
        bit       rdy;
        mode        = RX_ALWAYS;
        mode_left   = 0;
        hold_left   = 0;
        hold_served = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_result(m_tdata[SMP_W-1:0]);
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (mode)
                    RX_ALWAYS:  rdy = 1'b1;
                    RX_RANDOM:  rdy = ($urandom_range(0, 99) < 65);
                    default:    rdy = ((mode_left % 5) < 3);
                endcase
            end
            m_tready <= rdy;
        end
    end

    initial begin : stimulus
        int ph;
        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Single tap: rounding ties in both directions and full-scale samples.
        set_tap_count(1);
        push_coef(0, 16384);
        push_sample(1);
        push_sample(-1);
        push_sample(3);
        push_sample(-3);
        push_sample(32767);
        push_sample(-32768);
        push_sample(0);

        // Four taps with extreme coefficients drive the sum into both saturation limits.
        wait_drained();
        set_tap_count(4);
        push_coef(0, 32767);
        push_coef(1, 32767);
        push_coef(2, -32768);
        push_coef(3, 16384);
        push_coef(1023, -1);
        push_sample(32767);
        push_sample(32767);
        push_sample(32767);
        push_sample(-32768);
        push_sample(-32768);
        push_sample(-32768);
        push_sample(0);
        push_sample(1);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            no_gaps = (ph == 1 || ph == 7);
            run_random_phase(PHASE_TAPS[ph], PHASE_LEN[ph], ph == 1);
        end

        wait_drained();
        repeat (64) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/fcv_pkg.sv
hw/rtl/fir_convolver.sv
tb/fir_convolver_test.sv
